@@ rtl/uartrx_pkg.sv @@
// ----------------------------------------------------------------------------
// uartrx_pkg: shared types and constants for the UART receiver with FIFO
// Configuration layout, buffer sizing, link structs between the frame
// receiver and the ring buffer, and small pointer helpers.
// ----------------------------------------------------------------------------
package uartrx_pkg;

  // Ring buffer sizing; holds BUFFER_DEPTH-1 bytes
  localparam int BUFFER_DEPTH = 64;
  localparam int PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(BUFFER_DEPTH);

  // Field widths
  localparam int DELAY_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 6;
  localparam int COUNT_MAX   = 63;
  localparam int BITS_W      = 4;
  localparam int FRAME_BITS  = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_DELAY  = 3'd0,
    REG_BIT_PERIOD    = 3'd1,
    REG_STOP_DELAY    = 3'd2,
    REG_INVERT_LINE   = 3'd3,
    REG_LISTEN_ENABLE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DELAY_W-1:0] center_delay;
    logic [DELAY_W-1:0] bit_period;
    logic [DELAY_W-1:0] stop_delay;
    logic               invert_line;
    logic               listen_enable;
  } rx_cfg_t;

  // Completed byte from the frame receiver
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_byte_t;

  // Buffer status as seen before the current tick
  typedef struct packed {
    logic [BYTE_W-1:0]  head_byte;
    logic               head_valid;
    logic [COUNT_W-1:0] bytes_available;
    logic               overflow_seen;
  } ring_status_t;

  // A delay of zero behaves as one tick
  function automatic logic [DELAY_W-1:0] at_least_one(input logic [DELAY_W-1:0] d);
    return (d == '0) ? DELAY_W'(1) : d;
  endfunction

  // Advance a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  // Clamp the fill count to the reported field range
  function automatic logic [COUNT_W-1:0] sat_count(input logic [PTR_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : w[COUNT_W-1:0];
  endfunction

endpackage

@@ rtl/uartrx_frame.sv @@
// ----------------------------------------------------------------------------
// uartrx_frame: start detect and bit timing for one 8N1 frame
// Counts ticks through centering, data and stop waits, shifts data bits
// LSB first and presents a completed byte in the tick of its last sample.
// ----------------------------------------------------------------------------
module uartrx_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,      // one tick accepted
  input  logic                abort,     // listen enable dropped
  input  uartrx_pkg::rx_cfg_t cfg,
  input  logic                rx_level,
  output logic                busy,
  output uartrx_pkg::rx_byte_t push
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CENTER,
    PH_DATA,
    PH_STOP
  } phase_t;

  phase_t                                phase;
  logic [uartrx_pkg::DELAY_W-1:0]        tick_count;
  logic [uartrx_pkg::BITS_W-1:0]         bits_left;
  logic [uartrx_pkg::BYTE_W-1:0]         shift_byte;

  logic [uartrx_pkg::DELAY_W-1:0]        tick_dec;
  logic [uartrx_pkg::BITS_W-1:0]         bits_dec;
  logic [uartrx_pkg::BYTE_W-1:0]         shift_in;

  // Decrements and the shifted byte for this tick
  always_comb begin
    tick_dec = tick_count - 1'b1;
    bits_dec = bits_left - 1'b1;
    shift_in = {rx_level, shift_byte[uartrx_pkg::BYTE_W-1:1]};
    push.valid = step && cfg.listen_enable && (phase == PH_DATA) &&
                 (tick_dec == '0) && (bits_dec == '0);
    push.data  = cfg.invert_line ? ~shift_in : shift_in;
  end

  assign busy = (phase != PH_IDLE);

  // Advance the frame state once per tick
  always_ff @(posedge clk) begin
    if (rst || abort) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bits_left  <= '0;
      shift_byte <= '0;
    end else if (step) begin
      if (!cfg.listen_enable) begin
        phase      <= PH_IDLE;
        tick_count <= '0;
        bits_left  <= '0;
        shift_byte <= '0;
      end else begin
        unique case (phase)
          PH_IDLE: begin
            if (rx_level == cfg.invert_line) begin
              phase      <= PH_CENTER;
              tick_count <= uartrx_pkg::at_least_one(cfg.center_delay);
              shift_byte <= '0;
              bits_left  <= uartrx_pkg::BITS_W'(uartrx_pkg::FRAME_BITS);
            end
          end
          PH_CENTER: begin
            if (tick_dec == '0) begin
              phase      <= PH_DATA;
              tick_count <= uartrx_pkg::at_least_one(cfg.bit_period);
            end else begin
              tick_count <= tick_dec;
            end
          end
          PH_DATA: begin
            if (tick_dec == '0) begin
              shift_byte <= shift_in;
              bits_left  <= bits_dec;
              if (bits_dec == '0) begin
                phase      <= PH_STOP;
                tick_count <= uartrx_pkg::at_least_one(cfg.stop_delay);
              end else begin
                tick_count <= uartrx_pkg::at_least_one(cfg.bit_period);
              end
            end else begin
              tick_count <= tick_dec;
            end
          end
          PH_STOP: begin
            if (tick_dec == '0) begin
              phase      <= PH_IDLE;
              tick_count <= '0;
              bits_left  <= '0;
              shift_byte <= '0;
            end else begin
              tick_count <= tick_dec;
            end
          end
          default: begin
            phase <= PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/uartrx_ring.sv @@
// ----------------------------------------------------------------------------
// uartrx_ring: ring buffer of received bytes with sticky overflow
// Pop, overflow clear and flush act before the push of the same tick.
// The head byte is registered from the next read pointer, with
// a forward path for a byte written to that slot in the same cycle.
// ----------------------------------------------------------------------------
module uartrx_ring (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,           // one tick accepted
  input  logic                     clear_all,      // listen enable raised
  input  logic                     listen_enable,
  input  logic                     pop_req,
  input  logic                     clear_overflow,
  input  logic                     flush,
  input  uartrx_pkg::rx_byte_t     push,
  output uartrx_pkg::ring_status_t status
);

  localparam int PW = uartrx_pkg::PTR_W;

  logic [PW-1:0]                 rd_ptr;
  logic [PW-1:0]                 wr_ptr;
  logic                          ovf;

  logic [PW:0]                   wrap_diff;
  logic [PW-1:0]                 count;
  logic                          valid;
  logic [PW-1:0]                 rd_mid;
  logic [PW-1:0]                 wr_mid;
  logic                          ovf_mid;
  logic                          full;
  logic                          we;
  logic [PW-1:0]                 rd_ptr_next;
  logic [PW-1:0]                 wr_ptr_next;
  logic                          ovf_next;

  logic [uartrx_pkg::BYTE_W-1:0] ring_mem [uartrx_pkg::BUFFER_DEPTH];
  logic [uartrx_pkg::BYTE_W-1:0] rd_data;
  logic [uartrx_pkg::BYTE_W-1:0] byp_data;
  logic                          byp_hit;
  logic [uartrx_pkg::BYTE_W-1:0] head;

  // Fill level and head from the state before this tick
  always_comb begin
    wrap_diff = {1'b0, wr_ptr} + uartrx_pkg::DEPTH_EXT - {1'b0, rd_ptr};
    count     = (wr_ptr >= rd_ptr) ? PW'(wr_ptr - rd_ptr) : wrap_diff[PW-1:0];
    valid     = listen_enable && (count != '0);
    head      = byp_hit ? byp_data : rd_data;
    status.head_byte       = valid ? head : '0;
    status.head_valid      = valid;
    status.bytes_available = listen_enable ? uartrx_pkg::sat_count(count) : '0;
    status.overflow_seen   = ovf;
  end

  // Pop, clear and flush first, then the push
  always_comb begin
    rd_mid  = (pop_req && valid) ? uartrx_pkg::ptr_inc(rd_ptr) : rd_ptr;
    wr_mid  = wr_ptr;
    ovf_mid = clear_overflow ? 1'b0 : ovf;
    if (flush) begin
      rd_mid  = '0;
      wr_mid  = '0;
      ovf_mid = 1'b0;
    end
    full = (uartrx_pkg::ptr_inc(wr_mid) == rd_mid);
    we   = step && push.valid && !full;

    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    ovf_next    = ovf;
    if (clear_all) begin
      rd_ptr_next = '0;
      wr_ptr_next = '0;
      ovf_next    = 1'b0;
    end else if (step) begin
      rd_ptr_next = rd_mid;
      wr_ptr_next = push.valid && !full ? uartrx_pkg::ptr_inc(wr_mid) : wr_mid;
      ovf_next    = ovf_mid | (push.valid && full);
    end
  end

  // Hold pointers and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      ovf     <= 1'b0;
      byp_hit <= 1'b0;
    end else begin
      rd_ptr  <= rd_ptr_next;
      wr_ptr  <= wr_ptr_next;
      ovf     <= ovf_next;
      byp_hit <= we && (wr_mid == rd_ptr_next);
    end
  end

  // Byte store: one write port, one registered read at the next head
  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[wr_mid] <= push.data;
    end
    rd_data  <= ring_mem[rd_ptr_next];
    byp_data <= push.data;
  end

endmodule

@@ rtl/uart_receiver_with_fifo.sv @@
// ----------------------------------------------------------------------------
// uart_receiver_with_fifo: 8N1 UART receiver feeding a byte ring buffer
//
//   channel   direction  handshake              payload
//   s_*       in         s_tvalid / s_tready    one line tick with requests
//   m_*       out        m_tvalid / m_tready    buffer and receiver status
//   cfg_*     in         cfg_valid / cfg_ready  register index and value
//
// One word in gives one word out; a tick is taken every cycle while the
// output register is empty or being drained, so throughput is 1 per cycle.
// Status reflects the state before the tick and is registered on accept.
// Reset is synchronous; it empties the buffer and idles the receiver.
// A stall on m_tready holds the result and stops intake of new ticks.
// ----------------------------------------------------------------------------
module uart_receiver_with_fifo (
  input  logic                                  clk,
  input  logic                                  rst,
  // rx_level, pop_req, clear_overflow, flush, zero pad
  input  logic [uartrx_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // head_byte[7:0], head_valid, bytes_available[5:0], overflow_seen,
  // receiving, zero pad
  output logic [uartrx_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [uartrx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [uartrx_pkg::CFG_DATA_W-1:0]     cfg_data
);

  uartrx_pkg::rx_cfg_t      cfg;
  uartrx_pkg::rx_byte_t     push;
  uartrx_pkg::ring_status_t status;

  logic step;
  logic cfg_we;
  logic listen_rise;
  logic listen_fall;
  logic busy;
  logic rx_level;
  logic pop_req;
  logic clear_overflow;
  logic flush;

  // Unpack the input word
  assign rx_level       = s_tdata[0];
  assign pop_req        = s_tdata[1];
  assign clear_overflow = s_tdata[2];
  assign flush          = s_tdata[3];

  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Detect listen enable edges caused by a write
  assign listen_rise = cfg_we && (cfg_index == uartrx_pkg::REG_LISTEN_ENABLE) &&
                       cfg_data[0] && !cfg.listen_enable;
  assign listen_fall = cfg_we && (cfg_index == uartrx_pkg::REG_LISTEN_ENABLE) &&
                       !cfg_data[0] && cfg.listen_enable;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_delay  <= uartrx_pkg::DELAY_W'(1);
      cfg.bit_period    <= uartrx_pkg::DELAY_W'(1);
      cfg.stop_delay    <= uartrx_pkg::DELAY_W'(1);
      cfg.invert_line   <= 1'b0;
      cfg.listen_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (uartrx_pkg::cfg_reg_t'(cfg_index))
        uartrx_pkg::REG_CENTER_DELAY:  cfg.center_delay  <= cfg_data;
        uartrx_pkg::REG_BIT_PERIOD:    cfg.bit_period    <= cfg_data;
        uartrx_pkg::REG_STOP_DELAY:    cfg.stop_delay    <= cfg_data;
        uartrx_pkg::REG_INVERT_LINE:   cfg.invert_line   <= cfg_data[0];
        uartrx_pkg::REG_LISTEN_ENABLE: cfg.listen_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  uartrx_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .abort    (listen_fall),
    .cfg      (cfg),
    .rx_level (rx_level),
    .busy     (busy),
    .push     (push)
  );

  uartrx_ring u_ring (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .clear_all      (listen_rise),
    .listen_enable  (cfg.listen_enable),
    .pop_req        (pop_req),
    .clear_overflow (clear_overflow),
    .flush          (flush),
    .push           (push),
    .status         (status)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {7'b0, busy, status.overflow_seen, status.bytes_available,
                  status.head_valid, status.head_byte};
    end
  end

  // Head valid agrees with a nonzero fill count
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] == (m_tdata[14:9] != 6'd0)))
    else $error("head_valid disagrees with bytes_available");

  // An empty head reads as zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == 8'd0))
    else $error("head_byte nonzero without head_valid");

  // Receiver stays idle while not listening
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    !cfg.listen_enable |-> !busy)
    else $error("receiver busy while listening is off");

endmodule
